// File: rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and codes for the scalar kalman filter: sequencer states and
// configuration register indexes.
// ----------------------------------------------------------------------------
package skf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_EST,
    ST_EST,
    ST_MUL_P,
    ST_DIV_K,
    ST_DIV_P
  } skf_state_t;

  typedef logic [0:0] skf_cfg_idx_t;

  localparam skf_cfg_idx_t CFG_PROCESS_NOISE     = 1'b0;
  localparam skf_cfg_idx_t CFG_MEASUREMENT_NOISE = 1'b1;

endpackage

// File: rtl/core/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring unsigned divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in QW bits (upper numerator part below den).
// ----------------------------------------------------------------------------
module skf_div #(
  parameter int NW = 42,
  parameter int DW = 22,
  parameter int QW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   trial;
  logic [DW:0]   sub;
  logic          ge;
  logic          last;
  logic [DW-1:0] rem_step;
  logic [QW-1:0] acc_step;

  always_comb begin
    trial    = {rem_r, acc_r[QW-1]};
    sub      = trial - {1'b0, den};
    ge       = trial >= {1'b0, den};
    rem_step = ge ? sub[DW-1:0] : trial[DW-1:0];
    acc_step = {acc_r[QW-2:0], ge};
    last     = cnt_r == CW'(QW - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NW-1:QW];
      acc_r <= num[QW-1:0];
    end else if (busy_r) begin
      rem_r <= rem_step;
      acc_r <= acc_step;
    end
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

// File: rtl/core/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Shared signed multiplier with a registered product that holds while the
// enable is low.
// ----------------------------------------------------------------------------
module skf_mul #(
  parameter int AW = 21,
  parameter int BW = 22
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  logic signed [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// File: rtl/core/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// out_valid rises after ST_MUL_EST and ST_EST, the estimate being loaded in
// ST_EST once the output is not stalled. A sample is taken only in ST_IDLE;
// the bit-serial divider then runs for the gain and variance unless p+q+r is 0.
// Reset (synchronous): estimate 0, variance 1.0, gain 0, Q 0, R 0.2.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int VAR_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  skf_pkg::skf_cfg_idx_t          cfg_index,
  input  logic [VAR_FRAC_BITS+3:0]       cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_estimate
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = VAR_FRAC_BITS;
  localparam int VW = F + 4;
  localparam int DW = VW + 2;
  localparam int QW = VW;
  localparam int NW = DW + QW;
  localparam int MA = (SW + 1 > VW + 1) ? SW + 1 : VW + 1;
  localparam int MB = VW + 2;
  localparam int PW = MA + MB;
  localparam int EW = PW + 1;

  localparam logic [F:0]    GAIN_ONE = (F+1)'(1) << F;
  localparam logic [VW-1:0] VAR_ONE  = VW'(1) << F;
  localparam logic [VW-1:0] R_RESET  = VW'(((64'd2 << F) + 64'd5) / 64'd10);
  localparam logic signed [EW-1:0] EST_MAX = EW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] EST_MIN = EW'(-(64'sd1 <<< (SW - 1)));
  localparam logic signed [EW-1:0] HALF    = EW'(1) <<< (F - 1);

  skf_pkg::skf_state_t state_r, state_nxt;

  logic [VW-1:0]          q_r, r_r;
  logic signed [SW-1:0]   x_r, x_nxt;
  logic [VW-1:0]          p_r, p_nxt;
  logic [F:0]             k_r, k_nxt;
  logic signed [SW-1:0]   sample_r;
  logic [VW:0]            s_r;
  logic [DW-1:0]          d_r;
  logic signed [SW-1:0]   out_r;
  logic                   out_valid_r, out_valid_nxt;

  logic                   accept;
  logic                   out_load;
  logic                   mul_en;
  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [SW:0]     diff;
  logic signed [EW-1:0]   est_acc;
  logic signed [EW-1:0]   est_sh;
  logic signed [SW-1:0]   est_sat;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic                   div_done;
  logic [QW-1:0]          div_quot;

  assign accept   = in_valid && (state_r == skf_pkg::ST_IDLE);
  assign in_stall = state_r != skf_pkg::ST_IDLE;
  assign diff     = (SW+1)'(sample_r) - (SW+1)'(x_r);

  always_comb begin
    est_acc = (EW'(x_r) <<< F) + EW'(mul_p) + HALF;
    est_sh  = est_acc >>> F;
    if (est_sh > EST_MAX) begin
      est_sat = EST_MAX[SW-1:0];
    end else if (est_sh < EST_MIN) begin
      est_sat = EST_MIN[SW-1:0];
    end else begin
      est_sat = est_sh[SW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    out_load  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = MA'(diff);
    mul_b     = $signed(MB'(k_r));
    div_start = 1'b0;
    div_num   = (NW'(s_r) << F) + NW'(d_r >> 1);
    unique case (state_r)
      skf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = skf_pkg::ST_MUL_EST;
        end
      end
      skf_pkg::ST_MUL_EST: begin
        mul_en    = 1'b1;
        state_nxt = skf_pkg::ST_EST;
      end
      skf_pkg::ST_EST: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          x_nxt     = est_sat;
          state_nxt = skf_pkg::ST_MUL_P;
        end
      end
      skf_pkg::ST_MUL_P: begin
        mul_en = 1'b1;
        mul_a  = $signed(MA'(r_r));
        mul_b  = $signed(MB'(s_r));
        if (d_r == '0) begin
          k_nxt     = GAIN_ONE;
          p_nxt     = '0;
          state_nxt = skf_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = skf_pkg::ST_DIV_K;
        end
      end
      skf_pkg::ST_DIV_K: begin
        div_num = mul_p[NW-1:0] + NW'(d_r >> 1);
        if (div_done) begin
          k_nxt     = (div_quot > QW'(GAIN_ONE)) ? GAIN_ONE : div_quot[F:0];
          div_start = 1'b1;
          state_nxt = skf_pkg::ST_DIV_P;
        end
      end
      skf_pkg::ST_DIV_P: begin
        if (div_done) begin
          p_nxt     = div_quot;
          state_nxt = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= '0;
      r_r         <= R_RESET;
      x_r         <= '0;
      p_r         <= VAR_ONE;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      p_r         <= p_nxt;
      k_r         <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          skf_pkg::CFG_PROCESS_NOISE:     q_r <= cfg_wdata;
          skf_pkg::CFG_MEASUREMENT_NOISE: r_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
    if (state_r == skf_pkg::ST_MUL_EST) begin
      s_r <= (VW+1)'(p_r) + (VW+1)'(q_r);
      d_r <= DW'(p_r) + DW'(q_r) + DW'(r_r);
    end
    if (out_load) begin
      out_r <= est_sat;
    end
  end

  skf_mul #(
    .AW(MA),
    .BW(MB)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  skf_div #(
    .NW(NW),
    .DW(DW),
    .QW(QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid    = out_valid_r;
  assign out_estimate = out_r;

endmodule

// File: rtl/core/skf_chk.sv
// ----------------------------------------------------------------------------
// skf_chk
// Port-level checks for the scalar kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module skf_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_estimate
);

  // output beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_estimate))
    else $error("output beat dropped or changed under stall");

  // busy right after taking a sample
  a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again one cycle after a beat");

  // still busy as the sequencer reaches ST_EST
  a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 in_stall)
    else $error("input taken again two cycles after a beat");

  // no result right out of reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind scalar_kalman_filter skf_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_skf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_estimate (out_estimate)
);
